// ===== rtl/lru_kvc_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
package lru_kvc_pkg;

	// Width and reset value of the capacity register
	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Sequencer phases: wait for a word, compare all cells, update all cells
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_UPD
	} phase_t;

	// Command broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp;   // capture the key match of this cycle
		logic upd;   // apply the operation held in the op registers
		logic hit;   // the key was found in some cell
		logic put;   // the operation is a put
		logic full;  // occupancy has reached the capacity in use
	} cell_cmd_t;

endpackage

// ===== rtl/lru_kvc_cell.sv =====
// One cache cell: key, value, valid mark and recency rank, with free-slot chain.
module lru_kvc_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int RANK_W     = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lru_kvc_pkg::cell_cmd_t  cmd,
	input  logic [KEY_BITS-1:0]     op_key,
	input  logic [VALUE_BITS-1:0]   op_value,
	input  logic [RANK_W-1:0]       hit_rank,
	input  logic [RANK_W-1:0]       evict_rank,
	input  logic                    free_in,
	output logic                    free_out,
	output logic                    match,
	output logic                    valid,
	output logic [RANK_W-1:0]       rank,
	output logic [VALUE_BITS-1:0]   value
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;
	logic [RANK_W-1:0]     rank_q;
	logic                  match_q;
	logic                  evict_me;
	logic                  valid_post;
	logic                  insert_me;

	assign match      = valid_q && (key_q == op_key);
	assign evict_me   = cmd.full && valid_q && (rank_q == evict_rank);
	assign valid_post = valid_q && !evict_me;
	// the first free cell down the chain takes an inserted key
	assign free_out   = free_in || !valid_post;
	assign insert_me  = !valid_post && !free_in;

	assign valid = valid_q;
	assign rank  = rank_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
			match_q <= 1'b0;
		end else begin
			if (cmd.cmp) begin
				match_q <= match;
			end
			if (cmd.upd) begin
				if (cmd.hit) begin
					if (match_q) begin
						rank_q <= '0;
					end else if (valid_q && (rank_q < hit_rank)) begin
						rank_q <= rank_q + 1'b1;
					end
				end else if (cmd.put) begin
					if (insert_me) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end else if (evict_me) begin
						valid_q <= 1'b0;
						rank_q  <= '0;
					end else if (valid_post) begin
						rank_q <= rank_q + 1'b1;
					end
				end
			end
		end
	end

	// payload: written on insert, value also on a put hit
	always_ff @(posedge clk) begin
		if (cmd.upd && !cmd.hit && cmd.put && insert_me) begin
			key_q   <= op_key;
			value_q <= op_value;
		end else if (cmd.upd && cmd.hit && cmd.put && match_q) begin
			value_q <= op_value;
		end
	end

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Channels: an input channel (in_valid/in_ready) carries one word per operation:
// mode (0 get, 1 put), lookup_key and write_value. An output channel
// (out_valid/out_ready) returns one word per operation: hit and read_value.
// A get hit returns the stored value; a get miss returns all ones with hit clear;
// a put returns the value written, with hit set when the key was already present.
// A put miss inserts the key as most recent, evicting the least recent entry
// first once occupancy has reached the capacity in use.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data, always
// ready; 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES.
// Timing: a word is compared against every cell in the cycle after acceptance,
// then all cells update in the update phase, which waits while the output
// register is full, and the result word is registered by that update. A new
// word is taken in the update cycle, so a word is never compared before the one
// before it has updated; the pace is set by the compare-then-update pass over
// the row of cells, since every operation reads the recency left by the one before it.
// Reset clears every valid mark, rank and the occupancy; capacity returns to 16.
// Stall: the result waits in the output register; the update of the next word
// is held until that register is free, and input stays closed meanwhile.
module lru_key_value_cache_top #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic signed [KEY_BITS-1:0]          lookup_key,
	input  logic signed [VALUE_BITS-1:0]        write_value,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic signed [VALUE_BITS-1:0]        read_value,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lru_kvc_pkg::CAP_W-1:0]       cfg_data
);

	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);

	lru_kvc_pkg::phase_t    phase_q;
	lru_kvc_pkg::phase_t    phase_next;
	lru_kvc_pkg::cell_cmd_t cmd;

	logic [lru_kvc_pkg::CAP_W-1:0] cap_q;
	logic [OCC_W-1:0]              cap_eff;
	logic [OCC_W-1:0]              occ_q;

	// operation registers, loaded on acceptance
	logic                  op_put_q;
	logic [KEY_BITS-1:0]   op_key_q;
	logic [VALUE_BITS-1:0] op_value_q;

	// results of the compare pass
	logic                  hit_s2;
	logic [RANK_W-1:0]     hit_rank_s2;
	logic [VALUE_BITS-1:0] hit_value_s2;

	// output register
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;

	logic                  in_accept;
	logic                  out_space;
	logic                  upd_fire;
	logic                  any_match;
	logic [RANK_W-1:0]     match_rank;
	logic [VALUE_BITS-1:0] match_value;
	logic [RANK_W-1:0]     evict_rank;
	logic [VALUE_BITS-1:0] result_value;

	logic [MAX_ENTRIES-1:0] cell_match;
	logic [MAX_ENTRIES-1:0] cell_valid;
	logic [RANK_W-1:0]      cell_rank  [MAX_ENTRIES];
	logic [VALUE_BITS-1:0]  cell_value [MAX_ENTRIES];
	logic [MAX_ENTRIES:0]   free_chain;

	assign cfg_ready = 1'b1;
	assign out_space = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	// clamp the capacity register into 1..MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = OCC_W'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			cap_eff = OCC_W'(MAX_ENTRIES);
		end else begin
			cap_eff = OCC_W'(cap_q);
		end
	end

	// the least recent valid entry holds rank occupancy-1
	assign evict_rank = RANK_W'(occ_q - 1'b1);

	// sequencer: next phase
	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			lru_kvc_pkg::PH_IDLE: begin
				if (in_accept) phase_next = lru_kvc_pkg::PH_CMP;
			end
			lru_kvc_pkg::PH_CMP: begin
				phase_next = lru_kvc_pkg::PH_UPD;
			end
			lru_kvc_pkg::PH_UPD: begin
				if (out_space) begin
					phase_next = in_accept ? lru_kvc_pkg::PH_CMP : lru_kvc_pkg::PH_IDLE;
				end
			end
			default: phase_next = lru_kvc_pkg::PH_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready = 1'b0;
		upd_fire = 1'b0;
		unique case (phase_q)
			lru_kvc_pkg::PH_IDLE: begin
				in_ready = 1'b1;
			end
			lru_kvc_pkg::PH_CMP: begin
				in_ready = 1'b0;
			end
			lru_kvc_pkg::PH_UPD: begin
				in_ready = out_space;
				upd_fire = out_space;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.cmp  = (phase_q == lru_kvc_pkg::PH_CMP);
		cmd.upd  = upd_fire;
		cmd.hit  = hit_s2;
		cmd.put  = op_put_q;
		cmd.full = (occ_q >= cap_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lru_kvc_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_next;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lru_kvc_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// hold the operation for the compare and update cycles
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_put_q   <= mode;
			op_key_q   <= lookup_key;
			op_value_q <= write_value;
		end
	end

	// row of cells; the free-slot flag ripples from cell 0 upward
	assign free_chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lru_kvc_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.RANK_W     (RANK_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.op_key     (op_key_q),
			.op_value   (op_value_q),
			.hit_rank   (hit_rank_s2),
			.evict_rank (evict_rank),
			.free_in    (free_chain[i]),
			.free_out   (free_chain[i+1]),
			.match      (cell_match[i]),
			.valid      (cell_valid[i]),
			.rank       (cell_rank[i]),
			.value      (cell_value[i])
		);
	end

	// gather the single matching cell: keys are unique, so an OR suffices
	always_comb begin
		any_match   = 1'b0;
		match_rank  = '0;
		match_value = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			any_match   = any_match | cell_match[i];
			match_rank  = match_rank | (cell_rank[i] & {RANK_W{cell_match[i]}});
			match_value = match_value | (cell_value[i] & {VALUE_BITS{cell_match[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else if (cmd.cmp) begin
			hit_s2 <= any_match;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			hit_rank_s2  <= match_rank;
			hit_value_s2 <= match_value;
		end
	end

	// occupancy: only a put miss changes it, inserting one and evicting one when full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (upd_fire && op_put_q && !hit_s2) begin
			occ_q <= occ_q + OCC_W'(free_chain[MAX_ENTRIES]) - OCC_W'(cmd.full);
		end
	end

	// result word: a put echoes its value, a get hit returns the stored value, a get miss all ones
	always_comb begin
		if (op_put_q) begin
			result_value = op_value_q;
		end else if (hit_s2) begin
			result_value = hit_value_s2;
		end else begin
			result_value = {VALUE_BITS{1'b1}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			hit_q        <= hit_s2;
			read_value_q <= result_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

`ifndef SYNTHESIS
	// occupancy tracks the number of valid cells
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(occ_q))
		else $error("occupancy differs from valid cell count");

	// keys stay unique, so at most one cell matches
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lru_kvc_pkg::PH_CMP) |-> $onehot0(cell_match))
		else $error("several cells match one key");

	// a put miss always finds a free cell once eviction is applied
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && op_put_q && !hit_s2) |-> free_chain[MAX_ENTRIES])
		else $error("put miss found no free cell");

	// every update is followed by a result word
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> out_valid_q)
		else $error("update without result word");
`endif

endmodule
